FILE: rtl/core/pwlf_pkg.sv
// Shared types and constants for the piecewise-linear factor lookup.
`default_nettype none
package pwlf_pkg;

  localparam logic [15:0] UNITY_FACTOR = 16'd4096;

  // Register index, taken from paddr[2]
  localparam logic REG_SCALING_ENABLE = 1'b0;
  localparam logic REG_ENTRIES_IN_USE = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic       scaling_enable;
    logic [4:0] entries_in_use;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  temp;
    logic [15:0] fac;
  } entry_t;

endpackage
`default_nettype wire

FILE: rtl/core/piecewise_linear_factor_lookup_core.sv
// Top level: breakpoint table sequencer for the piecewise-linear factor lookup.
// Write item: stored at the accepting edge, busy stays low, one item a cycle while not busy.
// Query, scaling off: result in the cycle after acceptance, busy stays low.
// Query: first breakpoint's factor at/below it, last one's at/above the last, else
// scan for the segment ending at breakpoint k and interpolate (24-step divide); busy until done.
// Reset: scaling off, entry count 1, control cleared; table undefined until written.
`default_nettype none
module piecewise_linear_factor_lookup_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [3:0]  entry_index,
  input  wire logic [7:0]  entry_temperature,
  input  wire logic [15:0] entry_factor,
  input  wire logic [7:0]  temperature,
  output logic [15:0]      factor,
  output logic             done,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pwlf_pkg::*;

  localparam int IDX_W = $clog2(MAX_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_FIRST, S_LAST, S_SCAN, S_DIV} state_t;

  state_t            state;
  cfg_t              cfg;
  entry_t            rdata;
  entry_t            prev;
  entry_t            wdata;
  logic [7:0]        tq;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  last;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic [31:0]       cnt32;
  logic [31:0]       widx32;
  logic              accept;
  logic              we;
  logic              up;
  logic              hit;
  logic              div_start;
  logic              div_done;
  logic [15:0]       div_quo;
  logic [15:0]       diff;

  pwlf_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  assign busy   = (state != S_IDLE);
  assign accept = start & ~busy;

  // clamp count to 1..MAX_ENTRIES, keep index of the last breakpoint
  always_comb begin
    if (cfg.entries_in_use == 5'd0) begin
      cnt32 = 32'd1;
    end else if (32'(cfg.entries_in_use) > MAX_ENTRIES) begin
      cnt32 = 32'(MAX_ENTRIES);
    end else begin
      cnt32 = 32'(cfg.entries_in_use);
    end
    last = IDX_W'(cnt32 - 32'd1);
  end

  assign widx32     = 32'(entry_index);
  assign waddr      = widx32[IDX_W-1:0];
  assign we         = accept && (func == FUNC_WRITE) && (widx32 < 32'(MAX_ENTRIES));
  assign wdata.temp = entry_temperature;
  assign wdata.fac  = entry_factor;

  always_comb begin
    case (state)
      S_FIRST: raddr = last;
      S_LAST:  raddr = IDX_W'(1);
      S_SCAN:  raddr = k + IDX_W'(1);
      default: raddr = '0;
    endcase
  end

  pwlf_mem #(.DEPTH(MAX_ENTRIES), .AW(IDX_W)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign hit       = (tq >= prev.temp) && (tq < rdata.temp);
  assign div_start = (state == S_SCAN) && hit;
  assign diff      = (rdata.fac >= prev.fac) ? (rdata.fac - prev.fac)
                                             : (prev.fac - rdata.fac);

  pwlf_div u_div (
    .clk, .rst,
    .start (div_start),
    .diff  (diff),
    .dt    (8'(tq - prev.temp)),
    .span  (8'(rdata.temp - prev.temp)),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      k     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && (func == FUNC_QUERY)) begin
            tq <= temperature;
            if (!cfg.scaling_enable) begin
              factor <= UNITY_FACTOR;
              done   <= 1'b1;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          if (tq <= rdata.temp) begin
            factor <= rdata.fac;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            prev  <= rdata;
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (tq >= rdata.temp) begin
            factor <= rdata.fac;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            k     <= IDX_W'(1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            up    <= (rdata.fac >= prev.fac);
            state <= S_DIV;
          end else if (k == last) begin
            // table out of order: no segment holds the temperature
            factor <= UNITY_FACTOR;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            prev <= rdata;
            k    <= k + IDX_W'(1);
          end
        end
        S_DIV: begin
          if (div_done) begin
            factor <= up ? (prev.fac + div_quo) : (prev.fac - div_quo);
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> (state == S_IDLE))
    else $error("result strobe while sequencer busy");
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == S_DIV))
    else $error("divider finished outside divide state");
  assert property (@(posedge clk) disable iff (rst) (state == S_SCAN) |-> (k <= last))
    else $error("scan index beyond last breakpoint");
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_FIRST) |-> $past(accept && (func == FUNC_QUERY)))
    else $error("lookup started without an accepted query");

endmodule
`default_nettype wire

FILE: rtl/core/pwlf_regs.sv
// APB configuration registers: scaling enable and breakpoint count.
`default_nettype none
module pwlf_regs (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output pwlf_pkg::cfg_t        cfg
);
  import pwlf_pkg::*;

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scaling_enable <= 1'b0;
      cfg.entries_in_use <= 5'd1;
    end else if (wr) begin
      case (paddr[2])
        REG_SCALING_ENABLE: cfg.scaling_enable <= pwdata[0];
        REG_ENTRIES_IN_USE: cfg.entries_in_use <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SCALING_ENABLE: prdata = {31'd0, cfg.scaling_enable};
      REG_ENTRIES_IN_USE: prdata = {27'd0, cfg.entries_in_use};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/pwlf_mem.sv
// Breakpoint table: one write port, one registered read port.
`default_nettype none
module pwlf_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire pwlf_pkg::entry_t  wdata,
  input  wire logic [AW-1:0]     raddr,
  output pwlf_pkg::entry_t       rdata
);
  import pwlf_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/pwlf_div.sv
// Multiply delta by offset, then restoring divide by span, one bit a cycle.
`default_nettype none
module pwlf_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] diff,
  input  wire logic [7:0]  dt,
  input  wire logic [7:0]  span,
  output logic             done,
  output logic [15:0]      quo
);
  localparam int NW = 24;

  logic [15:0]     diff_r;
  logic [7:0]      dt_r;
  logic [7:0]      span_r;
  logic [NW-1:0]   num;
  logic [7:0]      rem;
  logic [4:0]      cnt;
  logic            mul_pend;
  logic            running;
  logic [8:0]      trial;
  logic            qbit;

  assign trial = {rem, num[NW-1]};
  assign qbit  = (trial >= {1'b0, span_r});
  assign quo   = num[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      running  <= 1'b0;
      done     <= 1'b0;
      cnt      <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        diff_r   <= diff;
        dt_r     <= dt;
        span_r   <= span;
        mul_pend <= 1'b1;
      end else if (mul_pend) begin
        mul_pend <= 1'b0;
        num      <= NW'(diff_r) * NW'(dt_r);
        rem      <= '0;
        cnt      <= '0;
        running  <= 1'b1;
      end else if (running) begin
        // quotient bits shift in at the bottom as the dividend leaves the top
        num <= {num[NW-2:0], qbit};
        rem <= qbit ? 8'(trial - {1'b0, span_r}) : trial[7:0];
        cnt <= cnt + 5'd1;
        if (cnt == 5'(NW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> $past(running))
    else $error("divider done without a running division");
  assert property (@(posedge clk) disable iff (rst) start |=> mul_pend)
    else $error("divider start not registered");
  assert property (@(posedge clk) disable iff (rst) !(mul_pend && running))
    else $error("divider multiply and iterate overlap");

endmodule
`default_nettype wire
